// File: rtl/binary_min_heap_queue_core_defines.svh
// Assertion macros used by the checker file of the heap queue.
`ifndef BINARY_MIN_HEAP_QUEUE_CORE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BMHQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("heap queue check failed");

// Consequent must hold in the cycle after the antecedent.
`define BMHQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("heap queue check failed");

`endif

// File: rtl/bmhq_pkg.sv
package bmhq_pkg;

  localparam int KEY_W         = 32;
  localparam int CMD_W         = 2;
  localparam int ENTRY_COUNT_W = 7;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ROOT,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_REPLY
  } bmhq_state_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_SET_FULL,
    OP_SET_EMPTY,
    OP_INS_SETUP,
    OP_RD_ROOT,
    OP_TAKE_ROOT,
    OP_TAKE_REMOVE,
    OP_WRITE_HOLD,
    OP_RD_PARENT,
    OP_UP_MOVE,
    OP_RD_CHILDREN,
    OP_DN_MOVE,
    OP_REPLY
  } bmhq_op_t;

  typedef struct packed {
    bmhq_op_t op;
  } bmhq_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             size_zero;
    logic             size_one;
    logic             size_full;
    logic             pos_zero;
    logic             left_in;
    logic             up_less;
    logic             dn_less;
  } bmhq_status_t;

endpackage

// File: rtl/bmhq_ctrl.sv
module bmhq_ctrl
  import bmhq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  bmhq_status_t status,
  output bmhq_cmd_t    cmd,
  output logic         busy
);

  bmhq_state_t state_r;
  bmhq_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (status.command)
          CMD_INSERT: state_nxt = status.size_full ? ST_REPLY : ST_UP_RD;
          CMD_REMOVE, CMD_PEEK: state_nxt = status.size_zero ? ST_REPLY : ST_ROOT;
          default: state_nxt = ST_REPLY;
        endcase
      end
      ST_ROOT: begin
        if (status.command == CMD_REMOVE && !status.size_one) begin
          state_nxt = ST_DN_RD;
        end else begin
          state_nxt = ST_REPLY;
        end
      end
      ST_UP_RD:  state_nxt = status.pos_zero ? ST_REPLY : ST_UP_CMP;
      ST_UP_CMP: state_nxt = status.up_less ? ST_UP_RD : ST_REPLY;
      ST_DN_RD:  state_nxt = status.left_in ? ST_DN_CMP : ST_REPLY;
      ST_DN_CMP: state_nxt = status.dn_less ? ST_DN_RD : ST_REPLY;
      ST_REPLY:  state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_IDLE;
    busy   = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy   = 1'b0;
        cmd.op = start ? OP_LOAD : OP_IDLE;
      end
      ST_DISPATCH: begin
        case (status.command)
          CMD_INSERT: cmd.op = status.size_full ? OP_SET_FULL : OP_INS_SETUP;
          CMD_REMOVE, CMD_PEEK: cmd.op = status.size_zero ? OP_SET_EMPTY : OP_RD_ROOT;
          default: cmd.op = OP_IDLE;
        endcase
      end
      ST_ROOT:   cmd.op = (status.command == CMD_REMOVE) ? OP_TAKE_REMOVE : OP_TAKE_ROOT;
      ST_UP_RD:  cmd.op = status.pos_zero ? OP_WRITE_HOLD : OP_RD_PARENT;
      ST_UP_CMP: cmd.op = status.up_less ? OP_UP_MOVE : OP_WRITE_HOLD;
      ST_DN_RD:  cmd.op = status.left_in ? OP_RD_CHILDREN : OP_WRITE_HOLD;
      ST_DN_CMP: cmd.op = status.dn_less ? OP_DN_MOVE : OP_WRITE_HOLD;
      ST_REPLY:  cmd.op = OP_REPLY;
      default: begin
        cmd.op = OP_IDLE;
        busy   = 1'b1;
      end
    endcase
  end

endmodule

// File: rtl/bmhq_datapath.sv
module bmhq_datapath
  import bmhq_pkg::*;
#(
  parameter int CAPACITY = 64
)
(
  input  logic                            clk,
  input  logic                            rst_n,
  input  bmhq_cmd_t                       cmd,
  output bmhq_status_t                    status,
  input  logic [CMD_W-1:0]                in_command,
  input  logic signed [KEY_W-1:0]         in_value,
  output logic                            out_valid,
  output logic signed [KEY_W-1:0]         out_min_value,
  output logic                            out_was_empty,
  output logic                            out_rejected_full,
  output logic [ENTRY_COUNT_W-1:0]        out_entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int SW = $clog2(CAPACITY + 1);
  localparam int CW = AW + 2;

  logic [KEY_W-1:0] mem [CAPACITY];

  logic [SW-1:0]           size_r, size_nxt;
  logic [AW-1:0]           pos_r, pos_nxt;
  logic signed [KEY_W-1:0] hold_r, hold_nxt;
  logic signed [KEY_W-1:0] result_r, result_nxt;
  logic [CMD_W-1:0]        command_r, command_nxt;
  logic                    empty_r, empty_nxt;
  logic                    full_r, full_nxt;
  logic signed [KEY_W-1:0] rd_a_r, rd_b_r;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [KEY_W-1:0] out_min_value_r, out_min_value_nxt;
  logic                    out_was_empty_r, out_was_empty_nxt;
  logic                    out_rejected_full_r, out_rejected_full_nxt;
  logic [ENTRY_COUNT_W-1:0] out_entry_count_r, out_entry_count_nxt;

  logic                    we;
  logic [AW-1:0]           waddr, ra, rb;
  logic signed [KEY_W-1:0] wdata;

  logic [CW-1:0]           size_w, left_w, right_w;
  logic [AW-1:0]           pos_m1, parent, last_idx;
  logic                    right_in, pick_right;
  logic [AW-1:0]           pick_idx;
  logic signed [KEY_W-1:0] pick_val;

  always_comb begin
    size_w     = CW'(size_r);
    left_w     = {1'b0, pos_r, 1'b1};
    right_w    = left_w + CW'(1);
    pos_m1     = pos_r - AW'(1);
    parent     = AW'(pos_m1 >> 1);
    last_idx   = AW'(size_r - SW'(1));
    right_in   = right_w < size_w;
    pick_right = right_in && (rd_b_r < rd_a_r);
    pick_idx   = pick_right ? right_w[AW-1:0] : left_w[AW-1:0];
    pick_val   = pick_right ? rd_b_r : rd_a_r;
  end

  always_comb begin
    status.command   = command_r;
    status.size_zero = size_r == '0;
    status.size_one  = size_r == SW'(1);
    status.size_full = size_r == SW'(CAPACITY);
    status.pos_zero  = pos_r == '0;
    status.left_in   = left_w < size_w;
    status.up_less   = hold_r < rd_a_r;
    status.dn_less   = pick_val < hold_r;
  end

  always_comb begin
    size_nxt              = size_r;
    pos_nxt               = pos_r;
    hold_nxt              = hold_r;
    result_nxt            = result_r;
    command_nxt           = command_r;
    empty_nxt             = empty_r;
    full_nxt              = full_r;
    out_valid_nxt         = 1'b0;
    out_min_value_nxt     = out_min_value_r;
    out_was_empty_nxt     = out_was_empty_r;
    out_rejected_full_nxt = out_rejected_full_r;
    out_entry_count_nxt   = out_entry_count_r;
    we    = 1'b0;
    waddr = pos_r;
    wdata = hold_r;
    ra    = '0;
    rb    = last_idx;
    case (cmd.op)
      OP_LOAD: begin
        command_nxt = in_command;
        hold_nxt    = in_value;
        result_nxt  = '0;
        empty_nxt   = 1'b0;
        full_nxt    = 1'b0;
      end
      OP_SET_FULL:  full_nxt = 1'b1;
      OP_SET_EMPTY: empty_nxt = 1'b1;
      OP_INS_SETUP: begin
        pos_nxt  = AW'(size_r);
        size_nxt = size_r + SW'(1);
      end
      OP_RD_ROOT: begin
        ra = '0;
        rb = last_idx;
      end
      OP_TAKE_ROOT: result_nxt = rd_a_r;
      OP_TAKE_REMOVE: begin
        result_nxt = rd_a_r;
        size_nxt   = size_r - SW'(1);
        hold_nxt   = rd_b_r;
        pos_nxt    = '0;
      end
      OP_WRITE_HOLD: begin
        we    = 1'b1;
        waddr = pos_r;
        wdata = hold_r;
      end
      OP_RD_PARENT: ra = parent;
      OP_UP_MOVE: begin
        we      = 1'b1;
        waddr   = pos_r;
        wdata   = rd_a_r;
        pos_nxt = parent;
      end
      OP_RD_CHILDREN: begin
        ra = left_w[AW-1:0];
        rb = right_w[AW-1:0];
      end
      OP_DN_MOVE: begin
        we      = 1'b1;
        waddr   = pos_r;
        wdata   = pick_val;
        pos_nxt = pick_idx;
      end
      OP_REPLY: begin
        out_valid_nxt         = 1'b1;
        out_min_value_nxt     = result_r;
        out_was_empty_nxt     = empty_r;
        out_rejected_full_nxt = full_r;
        out_entry_count_nxt   = ENTRY_COUNT_W'(size_r);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_r <= mem[ra];
    rd_b_r <= mem[rb];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r               <= pos_nxt;
    hold_r              <= hold_nxt;
    result_r            <= result_nxt;
    command_r           <= command_nxt;
    empty_r             <= empty_nxt;
    full_r              <= full_nxt;
    out_min_value_r     <= out_min_value_nxt;
    out_was_empty_r     <= out_was_empty_nxt;
    out_rejected_full_r <= out_rejected_full_nxt;
    out_entry_count_r   <= out_entry_count_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_min_value     = out_min_value_r;
  assign out_was_empty     = out_was_empty_r;
  assign out_rejected_full = out_rejected_full_r;
  assign out_entry_count   = out_entry_count_r;

endmodule

// File: rtl/binary_min_heap_queue_core.sv
// Priority queue of signed 32-bit keys kept as a binary min-heap in a single memory with one
// write and two registered read ports. An item is taken when start is high and busy is low;
// its result appears on the out_ ports for one cycle with out_valid high, in the first cycle in
// which busy is low again, and must be captured then since it cannot be held off. After the
// accepting edge busy stays high through the dispatch and reply states for an empty remove or
// peek, a full insert or the unused command, and through the root state as well for a peek.
// Each level of a sift costs a memory read state and a compare-and-write state; an insert
// climbs from the new last slot toward the root and a remove descends from the root. A new
// item may be started in the same cycle as the previous result is shown.
module binary_min_heap_queue_core
  import bmhq_pkg::*;
#(
  parameter int CAPACITY = 64
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         in_command,
  input  logic signed [KEY_W-1:0]  in_value,
  output logic                     out_valid,
  output logic signed [KEY_W-1:0]  out_min_value,
  output logic                     out_was_empty,
  output logic                     out_rejected_full,
  output logic [ENTRY_COUNT_W-1:0] out_entry_count
);

  bmhq_cmd_t    cmd;
  bmhq_status_t status;

  bmhq_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  bmhq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_command        (in_command),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_min_value     (out_min_value),
    .out_was_empty     (out_was_empty),
    .out_rejected_full (out_rejected_full),
    .out_entry_count   (out_entry_count)
  );

endmodule

// File: rtl/bmhq_checker.sv
`include "binary_min_heap_queue_core_defines.svh"

module bmhq_checker
  import bmhq_pkg::*;
#(
  parameter int CAPACITY = 64
)
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic                     out_valid,
  input logic signed [KEY_W-1:0]  out_min_value,
  input logic                     out_was_empty,
  input logic                     out_rejected_full,
  input logic [ENTRY_COUNT_W-1:0] out_entry_count
);

  logic accept;
  logic empty_reply;
  logic full_reply;
  logic zero_reply;
  logic full_count;

  assign accept      = start && !busy;
  assign empty_reply = out_valid && out_was_empty;
  assign full_reply  = out_valid && out_rejected_full;
  assign zero_reply  = (out_min_value == '0) && (out_entry_count == '0);
  assign full_count  = out_entry_count == ENTRY_COUNT_W'(CAPACITY);

  `BMHQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy)
  `BMHQ_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid)
  `BMHQ_ASSERT_SAME(a_flags_exclusive, clk, rst_n, empty_reply, !out_rejected_full)
  `BMHQ_ASSERT_SAME(a_empty_result, clk, rst_n, empty_reply, zero_reply)
  `BMHQ_ASSERT_SAME(a_full_count, clk, rst_n, full_reply, full_count)

endmodule

bind binary_min_heap_queue_core bmhq_checker #(.CAPACITY(CAPACITY)) u_bmhq_checker (.*);
